/* hdl/ossq_pkg.sv */
// Shared types, constants and register map of the one-shot step sequencer.
package ossq_pkg;

  // Default upper bound on the number of steps in one shot
  localparam int MAX_STEPS_DEF = 16;

  // Remainder lanes: dividend width, steps per pass and step counter width
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Scatter multipliers for the shunt and flip spots
  localparam logic [12:0] SHUNT_MUL = 13'd7649;
  localparam logic [12:0] FLIP_MUL  = 13'd137;
  localparam int          MUL_W     = 13;

  localparam logic [2:0] NO_NOTE = 3'd4;

  // Register reset values
  localparam logic [4:0] LEN_RST  = 5'd4;
  localparam logic [7:0] LATE_RST = 8'd100;

  // Register map, one word per register
  localparam int          ADDR_W     = 5;
  localparam logic [2:0]  REG_LEN    = 3'd0;
  localparam logic [2:0]  REG_MODE   = 3'd1;
  localparam logic [2:0]  REG_CHANCE = 3'd2;
  localparam logic [2:0]  REG_HEAT   = 3'd3;
  localparam logic [2:0]  REG_LATE   = 3'd4;

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_ARMED   = 2'd1,
    PH_PLAYING = 2'd2,
    PH_EOC     = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRONT,
    S_LOAD1,
    S_DIV1,
    S_LOAD2,
    S_DIV2,
    S_EVAL,
    S_COMMIT,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic        clock_rise;
    logic        start_rise;
    logic [15:0] random_shunt;
    logic [15:0] random_flip;
  } in_item_t;

  typedef struct packed {
    logic [2:0] note_index;
    logic       playing;
    logic       end_of_cycle;
    logic       note_random;
    logic       note_heated;
  } out_item_t;

  typedef struct packed {
    logic [4:0] sequence_length;
    logic       unstable_mode;
    logic [7:0] chance_level;
    logic [7:0] heat_level;
    logic [7:0] late_window;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;
    logic front;
    logic load1;
    logic load2;
    logic step;
    logic eval;
    logic commit;
    logic out_load;
  } ossq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clock_hit;
    logic out_free;
  } ossq_stat_t;

endpackage

/* hdl/one_shot_step_sequencer_unit.sv */
// Top level of the one-shot four-note step sequencer.
// An accepted item passes the front step and, if it clocks the sequencer, two 32-bit remainder
// passes at two bits a cycle, an evaluation and a commit before its result is registered.
// A new item is taken only after the last result is loaded; output stalls hold it back.
// Reset (synchronous, rst high): phase ready, counters and flags cleared, registers
// to length 4, stable mode, chance 0, heat 0, late window 100.
module one_shot_step_sequencer_unit #(
  parameter int MAX_STEPS = ossq_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ossq_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ossq_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ossq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ossq_pkg::cfg_t       cfg;
  ossq_pkg::ossq_cmd_t  cmd;
  ossq_pkg::ossq_stat_t stat;

  ossq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ossq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ossq_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* hdl/ossq_regs.sv */
// Configuration register file with an APB-style write and read port.
module ossq_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ossq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ossq_pkg::cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // Write the addressed register in the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sequence_length <= ossq_pkg::LEN_RST;
      cfg.unstable_mode   <= 1'b0;
      cfg.chance_level    <= 8'd0;
      cfg.heat_level      <= 8'd0;
      cfg.late_window     <= ossq_pkg::LATE_RST;
    end else if (wr_en) begin
      unique case (idx)
        ossq_pkg::REG_LEN:    cfg.sequence_length <= pwdata[4:0];
        ossq_pkg::REG_MODE:   cfg.unstable_mode   <= pwdata[0];
        ossq_pkg::REG_CHANCE: cfg.chance_level    <= pwdata[7:0];
        ossq_pkg::REG_HEAT:   cfg.heat_level      <= pwdata[7:0];
        ossq_pkg::REG_LATE:   cfg.late_window     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      ossq_pkg::REG_LEN:    prdata = {27'd0, cfg.sequence_length};
      ossq_pkg::REG_MODE:   prdata = {31'd0, cfg.unstable_mode};
      ossq_pkg::REG_CHANCE: prdata = {24'd0, cfg.chance_level};
      ossq_pkg::REG_HEAT:   prdata = {24'd0, cfg.heat_level};
      ossq_pkg::REG_LATE:   prdata = {24'd0, cfg.late_window};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/ossq_rem.sv */
// Restoring remainder lane, two dividend bits per cycle while step is high, MSB first.
module ossq_rem #(
  parameter int W = 5
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [ossq_pkg::DIV_W-1:0] dividend,
  input  logic [W-1:0]               divisor,
  output logic [W-1:0]               rem
);

  logic [ossq_pkg::DIV_W-1:0] sreg;
  logic [W:0]                 t1;
  logic [W:0]                 t2;
  logic [W-1:0]               r1;
  logic [W-1:0]               r2;

  // Two chained compare and subtract steps
  always_comb begin
    t1 = {rem, sreg[ossq_pkg::DIV_W-1]};
    r1 = (t1 >= {1'b0, divisor}) ? W'(t1 - {1'b0, divisor}) : W'(t1);
    t2 = {r1, sreg[ossq_pkg::DIV_W-2]};
    r2 = (t2 >= {1'b0, divisor}) ? W'(t2 - {1'b0, divisor}) : W'(t2);
  end

  // Load the dividend, then shift two bits in per step
  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= dividend;
      rem  <= '0;
    end else if (step) begin
      sreg <= {sreg[ossq_pkg::DIV_W-3:0], 2'b00};
      rem  <= r2;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) step |=> rem < $past(divisor))
    else $error("remainder not reduced below divisor");
`endif

endmodule

/* hdl/ossq_ctrl.sv */
// Sequencing controller: steps one item through front, on a clock two remainder passes and commit, then output.
module ossq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ossq_pkg::ossq_stat_t stat,
  output ossq_pkg::ossq_cmd_t  cmd
);

  ossq_pkg::ctl_state_t         state;
  ossq_pkg::ctl_state_t         state_next;
  logic [ossq_pkg::CNT_W-1:0]   cnt;
  logic [ossq_pkg::CNT_W-1:0]   cnt_next;
  logic                         cnt_last;

  assign cnt_last = (cnt == ossq_pkg::CNT_W'(ossq_pkg::DIV_STEPS - 1));

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ossq_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cnt_next   = '0;
    unique case (state)
      ossq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = ossq_pkg::S_FRONT;
        end
      end
      ossq_pkg::S_FRONT: begin
        cmd.front  = 1'b1;
        state_next = stat.clock_hit ? ossq_pkg::S_LOAD1 : ossq_pkg::S_OUT;
      end
      ossq_pkg::S_LOAD1: begin
        cmd.load1  = 1'b1;
        state_next = ossq_pkg::S_DIV1;
      end
      ossq_pkg::S_DIV1: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ossq_pkg::S_LOAD2;
        end
      end
      ossq_pkg::S_LOAD2: begin
        cmd.load2  = 1'b1;
        state_next = ossq_pkg::S_DIV2;
      end
      ossq_pkg::S_DIV2: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ossq_pkg::S_EVAL;
        end
      end
      ossq_pkg::S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ossq_pkg::S_COMMIT;
      end
      ossq_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ossq_pkg::S_OUT;
      end
      ossq_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ossq_pkg::S_IDLE;
        end
      end
      default: state_next = ossq_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_front: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ossq_pkg::S_FRONT)
    else $error("accepted item did not enter front step");
  a_pass_complete: assert property (@(posedge clk) disable iff (rst)
    state == ossq_pkg::S_LOAD2 |->
      ($past(state) == ossq_pkg::S_DIV1 &&
       $past(cnt) == ossq_pkg::CNT_W'(ossq_pkg::DIV_STEPS - 1)))
    else $error("second pass started before first pass finished");
`endif

endmodule

/* hdl/ossq_dp.sv */
// Sequencer datapath: phase and counters, remainder lanes, note rules, output register.
module ossq_dp #(
  parameter int MAX_STEPS = ossq_pkg::MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ossq_pkg::ossq_cmd_t  cmd,
  output ossq_pkg::ossq_stat_t stat,
  input  ossq_pkg::cfg_t       cfg,
  input  ossq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ossq_pkg::out_item_t  out_item
);

  localparam int LB_W = $clog2(MAX_STEPS + 2);
  localparam int PW   = LB_W + ossq_pkg::MUL_W;
  localparam int EW   = LB_W + 8;
  localparam int QW   = LB_W + 2;

  // Sequencer state
  ossq_pkg::in_item_t in_hold;
  ossq_pkg::phase_t   phase;
  logic [LB_W-1:0]    pos;
  logic [31:0]        note_count;
  logic [2:0]         held_note;
  logic [7:0]         late_count;
  logic               flag_eoc;
  logic               flag_rnd;
  logic               flag_heat;

  // Pass results and rule tests
  logic               pass2;
  logic [LB_W-1:0]    r_len_mod;
  logic [LB_W-1:0]    r_m_mod;
  logic               heat_spot;
  logic               shunt_spot;
  logic               flip_spot;
  logic               rnd_s;
  logic               rnd_f;
  logic [1:0]         stable_note;

  // Derived lengths
  logic [LB_W-1:0]    len_eff;
  logic [LB_W-1:0]    lbig;
  logic [LB_W-1:0]    m_eff;
  logic               lbig_small;
  logic               cool;

  // Front step signals
  logic               start_ok;
  logic               late_open;
  logic               clock_hit;

  // Remainder lanes
  logic [ossq_pkg::DIV_W-1:0] div_a;
  logic [ossq_pkg::DIV_W-1:0] div_b;
  logic [LB_W-1:0]            dsr_a;
  logic [LB_W-1:0]            rem_a;
  logic [LB_W-1:0]            rem_b;
  logic [PW-1:0]              prod_shunt;
  logic [PW-1:0]              prod_flip;

  // Stable note thresholds
  logic [QW-1:0]      r4;
  logic [QW-1:0]      lb1;
  logic [QW-1:0]      lb2;
  logic [QW-1:0]      lb3;

  // Commit values
  logic [1:0]         note_v;
  logic               none_v;
  logic               heat_v;
  logic               shunt_v;
  logic               flip_v;
  logic               can_v;
  logic               rnd_v;
  logic               pos_last;
  logic               past_end;
  ossq_pkg::phase_t   phase_c;
  logic [LB_W-1:0]    pos_c;
  logic [31:0]        nc_c;

  // Clamp the length and form the note length and spot modulus
  always_comb begin
    if (cfg.sequence_length == 5'd0) begin
      len_eff = LB_W'(1);
    end else if (32'(cfg.sequence_length) > 32'(MAX_STEPS)) begin
      len_eff = LB_W'(MAX_STEPS);
    end else begin
      len_eff = LB_W'(cfg.sequence_length);
    end
    lbig       = len_eff + LB_W'(cfg.unstable_mode);
    lbig_small = (lbig <= LB_W'(2));
    m_eff      = lbig_small ? LB_W'(1) : lbig - LB_W'(2);
    cool       = !(cfg.heat_level[7] && (|cfg.heat_level[6:0]));
  end

  // Start edge, late window and the effective clock
  assign start_ok  = in_hold.start_rise &&
                     (phase == ossq_pkg::PH_READY || phase == ossq_pkg::PH_EOC);
  assign late_open = (late_count != 8'd0);
  assign clock_hit = in_hold.clock_rise || (start_ok && late_open);

  assign stat.clock_hit = clock_hit;
  assign stat.out_free  = !out_valid || !out_stall;

  // Pass one: note_count mod note length and mod spot modulus.
  // Pass two: scattered spot positions mod spot modulus.
  assign prod_shunt = PW'(rem_b) * PW'(ossq_pkg::SHUNT_MUL);
  assign prod_flip  = PW'(rem_b) * PW'(ossq_pkg::FLIP_MUL);
  assign div_a      = cmd.load2 ? ossq_pkg::DIV_W'(prod_shunt) : note_count;
  assign div_b      = cmd.load2 ? ossq_pkg::DIV_W'(prod_flip) : note_count;
  assign dsr_a      = pass2 ? m_eff : lbig;

  ossq_rem #(.W(LB_W)) u_rem_a (
    .clk      (clk),
    .load     (cmd.load1 | cmd.load2),
    .step     (cmd.step),
    .dividend (div_a),
    .divisor  (dsr_a),
    .rem      (rem_a)
  );

  ossq_rem #(.W(LB_W)) u_rem_b (
    .clk      (clk),
    .load     (cmd.load1 | cmd.load2),
    .step     (cmd.step),
    .dividend (div_b),
    .divisor  (m_eff),
    .rem      (rem_b)
  );

  // Quarter of the note length that the remainder falls in
  always_comb begin
    r4  = {r_len_mod, 2'b00};
    lb1 = QW'(lbig);
    lb2 = {lb1[QW-2:0], 1'b0};
    lb3 = lb1 + lb2;
  end

  // Pick the note and the next sequencer state on a clock
  always_comb begin
    pos_last = (len_eff > LB_W'(1)) && (pos == len_eff - LB_W'(1));
    past_end = (pos >= len_eff);
    note_v   = 2'd0;
    none_v   = 1'b0;
    heat_v   = 1'b0;
    shunt_v  = 1'b0;
    flip_v   = 1'b0;
    can_v    = 1'b0;
    rnd_v    = 1'b0;
    if (pos == '0 && cool) begin
      note_v = 2'd0;
    end else if (pos_last && cool) begin
      note_v = 2'd3;
    end else if (past_end) begin
      none_v = 1'b1;
    end else begin
      heat_v  = heat_spot;
      shunt_v = shunt_spot;
      flip_v  = flip_spot;
      note_v  = heat_spot ? note_count[1:0] : stable_note;
      can_v   = 1'b1;
    end
    if (lbig_small) begin
      can_v = 1'b1;
    end
    // Random draws toggle the rule decisions
    if (can_v) begin
      shunt_v = shunt_v ^ rnd_s;
      flip_v  = flip_v ^ rnd_f;
      rnd_v   = rnd_s | rnd_f;
    end
    if (!none_v) begin
      if (shunt_v) begin
        note_v = note_v + 2'd1;
      end
      if (flip_v) begin
        note_v = ~note_v;
      end
      if (note_v == stable_note) begin
        heat_v = 1'b0;
      end
    end
    // Advance the step or close the shot
    phase_c = phase;
    pos_c   = pos;
    nc_c    = note_count;
    unique case (phase)
      ossq_pkg::PH_PLAYING: begin
        if (past_end) begin
          phase_c = ossq_pkg::PH_EOC;
        end else begin
          pos_c = pos + LB_W'(1);
          nc_c  = note_count + 32'd1;
        end
      end
      ossq_pkg::PH_EOC: phase_c = ossq_pkg::PH_READY;
      ossq_pkg::PH_READY: none_v = 1'b1;
      ossq_pkg::PH_ARMED: none_v = 1'b1;
      default: none_v = 1'b1;
    endcase
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ossq_pkg::PH_READY;
      pos        <= '0;
      note_count <= 32'd0;
      held_note  <= 3'd0;
      late_count <= 8'd0;
      flag_eoc   <= 1'b0;
      flag_rnd   <= 1'b0;
      flag_heat  <= 1'b0;
    end else if (cmd.front) begin
      late_count <= clock_hit ? cfg.late_window :
                    (late_open ? late_count - 8'd1 : 8'd0);
      if (clock_hit && (start_ok || phase == ossq_pkg::PH_ARMED)) begin
        phase <= ossq_pkg::PH_PLAYING;
        pos   <= '0;
        if (!cfg.unstable_mode) begin
          note_count <= 32'd0;
        end
      end else if (start_ok) begin
        phase <= ossq_pkg::PH_ARMED;
      end
    end else if (cmd.commit) begin
      phase      <= phase_c;
      pos        <= pos_c;
      note_count <= nc_c;
      held_note  <= none_v ? ossq_pkg::NO_NOTE : {1'b0, note_v};
      flag_eoc   <= (phase_c == ossq_pkg::PH_EOC);
      flag_rnd   <= !none_v && rnd_v;
      flag_heat  <= !none_v && heat_v;
    end
  end

  // Latch the item, pass results and rule tests
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_hold <= in_item;
    end
    if (cmd.load1) begin
      pass2 <= 1'b0;
    end else if (cmd.load2) begin
      pass2     <= 1'b1;
      r_len_mod <= rem_a;
      r_m_mod   <= rem_b;
    end
    if (cmd.eval) begin
      heat_spot   <= EW'({r_m_mod, 7'd0}) < EW'(cfg.heat_level) * EW'(m_eff);
      shunt_spot  <= cfg.heat_level[7] &&
                     (EW'({rem_a, 8'd0}) < EW'(cfg.heat_level[6:0]) * EW'(m_eff));
      flip_spot   <= cfg.heat_level[7] &&
                     (EW'({rem_b, 8'd0}) < EW'(cfg.heat_level[6:0]) * EW'(m_eff));
      rnd_s       <= cfg.chance_level[7] &&
                     (in_hold.random_shunt < {1'b0, cfg.chance_level[6:0], 8'd0});
      rnd_f       <= in_hold.random_flip < {1'b0, cfg.chance_level, 7'd0};
      stable_note <= (r4 >= lb3) ? 2'd3 : (r4 >= lb2) ? 2'd2 : (r4 >= lb1) ? 2'd1 : 2'd0;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.note_index   <= held_note;
      out_item.playing      <= (phase == ossq_pkg::PH_PLAYING);
      out_item.end_of_cycle <= flag_eoc;
      out_item.note_random  <= flag_rnd;
      out_item.note_heated  <= flag_heat;
    end
  end

`ifndef NO_ASSERTIONS
  a_note_range: assert property (@(posedge clk) disable iff (rst)
    held_note <= ossq_pkg::NO_NOTE)
    else $error("held note out of range");
  a_count_only_on_clock: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.front) && !$past(cmd.commit)) |-> $stable(note_count))
    else $error("note count moved outside front or commit");
`endif

endmodule
